@@ src/rpbe_pkg.sv @@
// shared types, constants and helpers for the relocation page block encoder
package rpbe_pkg;

	localparam int unsigned OFF_W       = 20;
	localparam int unsigned CNT_W       = 17;
	localparam int unsigned MAX_RESULTS = 6;
	localparam int unsigned RES_IDX_W   = 3;
	localparam int unsigned FIFO_DEPTH  = 16;
	localparam int unsigned FIFO_AW     = 4;
	localparam int unsigned FIFO_CW     = 5;

	localparam logic [OFF_W-1:0] OFF_LIMIT  = 20'hFFFFF;
	localparam logic [CNT_W-1:0] MAX_RELOCS = 17'd65536;
	localparam logic [15:0]      ENTRY_TAG  = 16'h3000;
	localparam logic [3:0]       HDR_BYTES  = 4'd8;
	localparam logic [3:0]       HALF_BYTES = 4'd2;

	localparam logic [2:0] ADDR_MASK = 3'd0;

	typedef enum logic [1:0] {
		KIND_ENTRY  = 2'd0,
		KIND_PAD    = 2'd1,
		KIND_HEADER = 2'd2,
		KIND_TOTAL  = 2'd3
	} rec_kind_t;

	typedef struct packed {
		logic [31:0] addr;
		logic [3:0]  sec;
		logic        last;
	} item_t;

	typedef struct packed {
		rec_kind_t        kind;
		logic [OFF_W-1:0] offset;
		logic [31:0]      value;
		logic [OFF_W-1:0] bytes;
		logic [CNT_W-1:0] total;
		logic             ovf;
		logic             last;
	} rec_t;

	// saturating offset advance, msb is the overflow indication
	function automatic logic [OFF_W:0] adv_off(input logic [OFF_W-1:0] wo,
		input logic [3:0] n);
		logic [OFF_W:0] sum;
		sum = {1'b0, wo} + {{(OFF_W-3){1'b0}}, n};
		if (sum > {1'b0, OFF_LIMIT}) begin
			adv_off = {1'b1, OFF_LIMIT};
		end else begin
			adv_off = sum;
		end
	endfunction

	function automatic rec_t make_rec(input rec_kind_t kind, input logic [OFF_W-1:0] offset,
		input logic [31:0] value, input logic [OFF_W-1:0] bytes,
		input logic [CNT_W-1:0] total, input logic ovf);
		rec_t r;
		r.kind   = kind;
		r.offset = offset;
		r.value  = value;
		r.bytes  = bytes;
		r.total  = total;
		r.ovf    = ovf;
		r.last   = 1'b0;
		make_rec = r;
	endfunction

endpackage

@@ src/rpbe_encoder.sv @@
// block encoder state and per-transaction record generation
module rpbe_encoder import rpbe_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic [15:0]          mask,
	input  logic                 proc,
	input  item_t                item,
	output logic [RES_IDX_W-1:0] push_n,
	output rec_t                 recs [MAX_RESULTS]
);

	logic [OFF_W-3-1+3:0] open_page_q;
	logic                 block_open_q;
	logic [OFF_W-1:0]     block_start_q;
	logic [OFF_W-1:0]     write_offset_q;
	logic [CNT_W-1:0]     entry_count_q;
	logic                 overflow_q;

	logic [19:0]          pg_v;
	logic                 bo_v;
	logic [OFF_W-1:0]     bs_v;
	logic [OFF_W-1:0]     wo_v;
	logic [CNT_W-1:0]     cnt_v;
	logic                 ovf_v;
	logic [RES_IDX_W-1:0] n_v;
	logic [OFF_W:0]       adv_v;
	logic [OFF_W-1:0]     size_v;
	logic                 keep;
	rec_t                 rec_v [MAX_RESULTS];

	assign keep = mask[item.sec];

	always_comb begin
		pg_v   = open_page_q;
		bo_v   = block_open_q;
		bs_v   = block_start_q;
		wo_v   = write_offset_q;
		cnt_v  = entry_count_q;
		ovf_v  = overflow_q;
		n_v    = '0;
		adv_v  = '0;
		size_v = '0;
		for (int i = 0; i < MAX_RESULTS; i++) begin
			rec_v[i] = make_rec(KIND_ENTRY, '0, '0, '0, '0, 1'b0);
		end
		if (keep) begin
			if (!bo_v || item.addr[31:12] != pg_v) begin
				if (bo_v) begin
					if (wo_v[1:0] != bs_v[1:0]) begin
						rec_v[n_v] = make_rec(KIND_PAD, wo_v, '0, '0, '0, 1'b0);
						n_v = n_v + 1'b1;
						adv_v = adv_off(wo_v, HALF_BYTES);
						wo_v = adv_v[OFF_W-1:0];
						ovf_v = ovf_v | adv_v[OFF_W];
					end
					size_v = wo_v - bs_v;
					rec_v[n_v] = make_rec(KIND_HEADER, bs_v, {pg_v, 12'h000}, size_v,
						'0, 1'b0);
					n_v = n_v + 1'b1;
				end
				bs_v = wo_v;
				adv_v = adv_off(wo_v, HDR_BYTES);
				wo_v = adv_v[OFF_W-1:0];
				ovf_v = ovf_v | adv_v[OFF_W];
				pg_v = item.addr[31:12];
				bo_v = 1'b1;
			end
			rec_v[n_v] = make_rec(KIND_ENTRY, wo_v, {16'h0000, ENTRY_TAG | {4'h0,
				item.addr[11:0]}}, '0, '0, 1'b0);
			n_v = n_v + 1'b1;
			adv_v = adv_off(wo_v, HALF_BYTES);
			wo_v = adv_v[OFF_W-1:0];
			ovf_v = ovf_v | adv_v[OFF_W];
			if (cnt_v >= MAX_RELOCS) begin
				cnt_v = MAX_RELOCS;
				ovf_v = 1'b1;
			end else begin
				cnt_v = cnt_v + 1'b1;
			end
		end
		if (item.last) begin
			if (bo_v) begin
				if (wo_v[1:0] != bs_v[1:0]) begin
					rec_v[n_v] = make_rec(KIND_PAD, wo_v, '0, '0, '0, 1'b0);
					n_v = n_v + 1'b1;
					adv_v = adv_off(wo_v, HALF_BYTES);
					wo_v = adv_v[OFF_W-1:0];
					ovf_v = ovf_v | adv_v[OFF_W];
				end
				size_v = wo_v - bs_v;
				rec_v[n_v] = make_rec(KIND_HEADER, bs_v, {pg_v, 12'h000}, size_v,
					'0, 1'b0);
				n_v = n_v + 1'b1;
			end
			rec_v[n_v] = make_rec(KIND_TOTAL, '0, {12'h000, wo_v}, '0, cnt_v, ovf_v);
			n_v = n_v + 1'b1;
			pg_v  = '0;
			bo_v  = 1'b0;
			bs_v  = '0;
			wo_v  = '0;
			cnt_v = '0;
			ovf_v = 1'b0;
		end
		if (n_v != '0) begin
			rec_v[n_v - 1'b1].last = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			open_page_q    <= '0;
			block_open_q   <= 1'b0;
			block_start_q  <= '0;
			write_offset_q <= '0;
			entry_count_q  <= '0;
			overflow_q     <= 1'b0;
		end else if (proc) begin
			open_page_q    <= pg_v;
			block_open_q   <= bo_v;
			block_start_q  <= bs_v;
			write_offset_q <= wo_v;
			entry_count_q  <= cnt_v;
			overflow_q     <= ovf_v;
		end
	end

	assign push_n = proc ? n_v : '0;
	assign recs   = rec_v;

	a_close_clears: assert property (@(posedge clk) disable iff (!arst_n)
		proc && item.last |=> !block_open_q && write_offset_q == '0 && entry_count_q == '0)
		else $error("state not cleared after total record");

	a_start_below_offset: assert property (@(posedge clk) disable iff (!arst_n)
		block_open_q |-> write_offset_q >= block_start_q)
		else $error("open block starts beyond write offset");

	a_ovf_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		overflow_q && !(proc && item.last) |=> overflow_q)
		else $error("overflow flag dropped within a list");

	a_last_gives_total: assert property (@(posedge clk) disable iff (!arst_n)
		proc && item.last |-> push_n != '0)
		else $error("last transaction produced no records");

endmodule

@@ src/rpbe_fifo.sv @@
// result queue taking up to six records per cycle and draining one per cycle while out_stall is low
module rpbe_fifo import rpbe_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic [RES_IDX_W-1:0] push_n,
	input  rec_t                 recs [MAX_RESULTS],
	output logic                 room,
	output logic                 out_valid,
	input  logic                 out_stall,
	output rec_t                 out_rec
);

	rec_t               mem_q [FIFO_DEPTH];
	logic [FIFO_AW-1:0] wr_ptr_q;
	logic [FIFO_AW-1:0] rd_ptr_q;
	logic [FIFO_CW-1:0] count_q;
	logic               pop;

	assign out_valid = count_q != '0;
	assign pop       = out_valid && !out_stall;
	assign room      = count_q <= FIFO_CW'(FIFO_DEPTH - MAX_RESULTS);
	assign out_rec   = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		for (int i = 0; i < MAX_RESULTS; i++) begin
			if (RES_IDX_W'(i) < push_n) begin
				mem_q[wr_ptr_q + FIFO_AW'(i)] <= recs[i];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + FIFO_AW'(push_n);
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			count_q <= count_q + FIFO_CW'(push_n) - FIFO_CW'(pop);
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= FIFO_CW'(FIFO_DEPTH))
		else $error("queue count beyond depth");

	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		push_n != '0 |-> room)
		else $error("records pushed without room");

	a_count_track: assert property (@(posedge clk) disable iff (!arst_n)
		$past(arst_n) && $past(push_n) == '0 && !$past(pop) |-> $stable(count_q))
		else $error("queue count moved without push or pop");

endmodule

@@ src/reloc_page_block_encoder_top.sv @@
// top level of the relocation page block encoder
//   channel  direction  handshake          payload
//   in       sink       in_valid/in_stall  reloc_address, section_number, last_item
//   out      source     out_valid/out_stall record_kind .. last_result
//   cfg      apb        psel/penable       section_accept_mask at byte address 0
// one transaction is taken per cycle while in_stall is low; it is registered, then encoded combinationally
// an encoded transaction pushes zero to six records into a 16-entry result queue
// records leave one per cycle while out_stall is low, so a page change costs extra output cycles
// in_stall rises while a registered transaction waits and the queue lacks room for six more records
// arst_n clears all encoder state, the queue and the accept mask
module reloc_page_block_encoder_top import rpbe_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [31:0] reloc_address,
	input  logic [3:0]  section_number,
	input  logic        last_item,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  record_kind,
	output logic [19:0] byte_offset,
	output logic [31:0] record_value,
	output logic [19:0] block_bytes,
	output logic [16:0] entry_total,
	output logic        overflow_seen,
	output logic        last_result
);

	logic [15:0]          mask_q;
	item_t                item_s1;
	logic                 valid_s1;
	logic                 room;
	logic                 proc;
	logic                 in_accept;
	logic [RES_IDX_W-1:0] push_n;
	rec_t                 recs [MAX_RESULTS];
	rec_t                 out_rec;

	assign pready = 1'b1;
	assign prdata = (paddr == ADDR_MASK) ? {16'h0000, mask_q} : 32'h0000_0000;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_q <= '0;
		end else if (psel && penable && pwrite && paddr == ADDR_MASK) begin
			mask_q <= pwdata[15:0];
		end
	end

	assign proc      = valid_s1 && room;
	assign in_stall  = valid_s1 && !room;
	assign in_accept = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_accept) begin
			valid_s1 <= 1'b1;
		end else if (proc) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			item_s1.addr <= reloc_address;
			item_s1.sec  <= section_number;
			item_s1.last <= last_item;
		end
	end

	rpbe_encoder u_encoder (
		.clk    (clk),
		.arst_n (arst_n),
		.mask   (mask_q),
		.proc   (proc),
		.item   (item_s1),
		.push_n (push_n),
		.recs   (recs)
	);

	rpbe_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_n    (push_n),
		.recs      (recs),
		.room      (room),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_rec   (out_rec)
	);

	assign record_kind   = out_rec.kind;
	assign byte_offset   = out_rec.offset;
	assign record_value  = out_rec.value;
	assign block_bytes   = out_rec.bytes;
	assign entry_total   = out_rec.total;
	assign overflow_seen = out_rec.ovf;
	assign last_result   = out_rec.last;

endmodule

@@ bench/reloc_page_block_encoder_top_test.sv @@
// self-checking bench for the relocation page block encoder: queued stimulus, predicted records
module reloc_page_block_encoder_top_test import rpbe_pkg::*;;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [2:0]  paddr = ADDR_MASK;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [31:0] reloc_address = '0;
	logic [3:0]  section_number = '0;
	logic        last_item = 1'b0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [1:0]  record_kind;
	logic [19:0] byte_offset;
	logic [31:0] record_value;
	logic [19:0] block_bytes;
	logic [16:0] entry_total;
	logic        overflow_seen;
	logic        last_result;

	reloc_page_block_encoder_top DUT (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.reloc_address(reloc_address),
		.section_number(section_number),
		.last_item(last_item),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.record_kind(record_kind),
		.byte_offset(byte_offset),
		.record_value(record_value),
		.block_bytes(block_bytes),
		.entry_total(entry_total),
		.overflow_seen(overflow_seen),
		.last_result(last_result)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	item_t pending_items[$];
	rec_t  pending_records[$];
	rec_t  batch[$];
	item_t cur_item;
	int    items_sent = 0;
	int    records_seen = 0;
	int    errors = 0;

	// encoder state as the bench sees it
	logic [15:0]      accept_mask = '0;
	logic [19:0]      cur_page = '0;
	logic             have_block = 1'b0;
	logic [OFF_W-1:0] block_base = '0;
	logic [OFF_W-1:0] fill_offset = '0;
	logic [CNT_W-1:0] entry_cnt = '0;
	logic             sticky_ovf = 1'b0;

	function automatic bit take_break();
		return !(items_sent >= 120 && items_sent < 220) && $urandom_range(0, 99) < 9;
	endfunction

	task automatic bump(input logic [3:0] n);
		if (fill_offset > OFF_LIMIT - n) begin
			fill_offset = OFF_LIMIT;
			sticky_ovf = 1'b1;
		end else begin
			fill_offset = fill_offset + n;
		end
	endtask

	task automatic emit(input rec_kind_t kind, input logic [OFF_W-1:0] off,
		input logic [31:0] val, input logic [OFF_W-1:0] bytes,
		input logic [CNT_W-1:0] total, input logic ovf);
		batch.push_back('{kind, off, val, bytes, total, ovf, 1'b0});
	endtask

	task automatic close_block();
		logic [OFF_W-1:0] span;
		if (have_block) begin
			span = fill_offset - block_base;
			if (span[1:0] != 2'd0) begin
				emit(KIND_PAD, fill_offset, '0, '0, '0, 1'b0);
				bump(HALF_BYTES);
			end
			span = fill_offset - block_base;
			emit(KIND_HEADER, block_base, {cur_page, 12'h000}, span, '0, 1'b0);
			have_block = 1'b0;
		end
	endtask

	task automatic encode_reloc(input item_t it);
		rec_t r;
		batch.delete();
		if (accept_mask[it.sec]) begin
			if (!have_block || it.addr[31:12] != cur_page) begin
				close_block();
				block_base = fill_offset;
				bump(HDR_BYTES);
				cur_page = it.addr[31:12];
				have_block = 1'b1;
			end
			emit(KIND_ENTRY, fill_offset, {16'h0000, ENTRY_TAG | {4'h0, it.addr[11:0]}},
				'0, '0, 1'b0);
			bump(HALF_BYTES);
			if (entry_cnt >= MAX_RELOCS) begin
				entry_cnt = MAX_RELOCS;
				sticky_ovf = 1'b1;
			end else begin
				entry_cnt = entry_cnt + 1'b1;
			end
		end
		if (it.last) begin
			close_block();
			emit(KIND_TOTAL, '0, {12'h000, fill_offset}, '0, entry_cnt, sticky_ovf);
			cur_page = '0;
			have_block = 1'b0;
			block_base = '0;
			fill_offset = '0;
			entry_cnt = '0;
			sticky_ovf = 1'b0;
		end
		if (batch.size() > 0) begin
			r = batch.pop_back();
			r.last = 1'b1;
			batch.push_back(r);
		end
		while (batch.size() > 0) begin
			pending_records.push_back(batch.pop_front());
		end
	endtask

	// input driver
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall) begin
				encode_reloc(cur_item);
				items_sent++;
			end
			if (!in_valid || !in_stall) begin
				if (pending_items.size() > 0 && !take_break()) begin
					cur_item = pending_items.pop_front();
					in_valid <= 1'b1;
					reloc_address <= cur_item.addr;
					section_number <= cur_item.sec;
					last_item <= cur_item.last;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	task automatic check_field(input string name, input logic [31:0] want,
		input logic [31:0] got);
		if (want !== got) begin
			if (errors < 40) begin
				$display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
			end
			errors++;
		end
	endtask

	// result monitor
	always @(posedge clk) begin
		rec_t want;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				records_seen++;
				if (pending_records.size() == 0) begin
					if (errors < 40) begin
						$display("%0t: unexpected transaction, expected none, actual kind %0d value %0h",
							$time, record_kind, record_value);
					end
					errors++;
				end else begin
					want = pending_records.pop_front();
					check_field("record_kind", 32'(want.kind), 32'(record_kind));
					check_field("byte_offset", 32'(want.offset), 32'(byte_offset));
					check_field("record_value", want.value, record_value);
					check_field("block_bytes", 32'(want.bytes), 32'(block_bytes));
					check_field("entry_total", 32'(want.total), 32'(entry_total));
					check_field("overflow_seen", 32'(want.ovf), 32'(overflow_seen));
					check_field("last_result", 32'(want.last), 32'(last_result));
				end
			end
			out_stall <= take_break();
		end
	end

	task automatic add_item(input logic [31:0] addr, input logic [3:0] sec, input logic last);
		pending_items.push_back('{addr, sec, last});
	endtask

	task automatic write_mask(input logic [15:0] m);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= ADDR_MASK;
		pwdata <= {16'h0000, m};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		accept_mask = m;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		if (prdata[15:0] !== m) begin
			$display("%0t: mask readback mismatch, expected %0h, actual %0h", $time, m,
				prdata[15:0]);
			errors++;
		end
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic settle();
		int quiet;
		int progress;
		quiet = 0;
		progress = records_seen + items_sent;
		while ((pending_items.size() > 0 || in_valid || pending_records.size() > 0)
			&& quiet < 5000) begin
			@(posedge clk);
			if (records_seen + items_sent != progress) begin
				progress = records_seen + items_sent;
				quiet = 0;
			end else begin
				quiet++;
			end
		end
		repeat (40) @(posedge clk);
		if (pending_items.size() > 0 || pending_records.size() > 0) begin
			$display("%0t: stalled, expected 0 outstanding, actual %0d items and %0d records",
				$time, pending_items.size(), pending_records.size());
			errors++;
			pending_records.delete();
		end
	endtask

	task automatic queue_random_lists(input int count);
		logic [19:0] pool [3];
		logic [19:0] pg;
		int len;
		int k;
		k = 0;
		while (k < count) begin
			len = $urandom_range(1, 24);
			pool[0] = 20'($urandom);
			pool[1] = pool[0] + 1'b1;
			pool[2] = 20'($urandom);
			pg = pool[$urandom_range(0, 2)];
			for (int i = 0; i < len; i++) begin
				if ($urandom_range(0, 19) == 0) begin
					add_item($urandom, 4'($urandom), $urandom_range(0, 29) == 0);
				end else begin
					if ($urandom_range(0, 2) == 0) begin
						pg = pool[$urandom_range(0, 2)];
					end
					add_item({pg, 12'($urandom)}, 4'($urandom), i == len - 1);
				end
			end
			k += len;
		end
	endtask

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// nothing kept under the reset mask, total record is zero
		add_item(32'h0000_1000, 4'd0, 1'b0);
		add_item(32'hFFFF_FFFF, 4'd15, 1'b0);
		add_item(32'h1234_5678, 4'd7, 1'b1);
		settle();

		write_mask(16'hFFFF);
		add_item(32'h0000_0000, 4'd0, 1'b0);
		add_item(32'h0000_0FFF, 4'd15, 1'b0);
		add_item(32'h0000_0ABC, 4'd5, 1'b0);
		add_item(32'hFFFF_F123, 4'd1, 1'b0);
		add_item(32'hFFFF_FFFF, 4'd2, 1'b1);
		settle();

		write_mask(16'h0001);
		add_item(32'h1234_5678, 4'd0, 1'b0);
		add_item(32'h1234_5000, 4'd3, 1'b0);
		add_item(32'h2000_0001, 4'd0, 1'b0);
		add_item(32'h2000_0002, 4'd9, 1'b1);
		add_item(32'hABCD_E00F, 4'd0, 1'b1);
		add_item(32'h1000_0010, 4'd0, 1'b0);
		add_item(32'h2000_0020, 4'd0, 1'b1);
		settle();

		write_mask(16'h8000);
		add_item(32'h5555_5555, 4'd15, 1'b0);
		add_item(32'hAAAA_AAAA, 4'd0, 1'b0);
		add_item(32'h5555_5AAA, 4'd15, 1'b1);
		settle();

		write_mask(16'h0000);
		add_item(32'h0F0F_0F0F, 4'd4, 1'b0);
		add_item(32'hF0F0_F0F0, 4'd11, 1'b1);
		settle();

		for (int p = 0; p < 5; p++) begin
			write_mask(16'($urandom) | (16'h0001 << $urandom_range(0, 15)));
			queue_random_lists(50);
			settle();
		end

		if (errors == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

	initial begin
		#200000000;
		$display("Some tests failed");
		$finish;
	end

endmodule

@@ sim.f @@
src/rpbe_pkg.sv
src/rpbe_encoder.sv
src/rpbe_fifo.sv
src/reloc_page_block_encoder_top.sv
bench/reloc_page_block_encoder_top_test.sv
